// ----- rtl/zero_suppressed_peak_decoder_assert.svh -----
// assertion macros for the zero-suppressed peak decoder
// expects i_clk and i_rst_n in the scope of each use
`ifndef ZERO_SUPPRESSED_PEAK_DECODER_ASSERT_SVH
`define ZERO_SUPPRESSED_PEAK_DECODER_ASSERT_SVH

`ifndef SYNTHESIS

// checked only while out of reset
`define ZSPD_ASSERT(label, prop) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error("zspd assertion failed");

// checked at every edge, reset included
`define ZSPD_ASSERT_ALWAYS(label, prop) \
    label: assert property (@(posedge i_clk) (prop)) \
        else $error("zspd assertion failed");

`else

`define ZSPD_ASSERT(label, prop)
`define ZSPD_ASSERT_ALWAYS(label, prop)

`endif

`endif

// ----- rtl/zspd_pkg.sv -----
// shared types and constants of the zero-suppressed peak decoder
// no dependencies
package zspd_pkg;

    localparam int WORD_W        = 16;
    localparam int INDEX_W       = 13;
    localparam int LENGTH_W      = 14;
    localparam int SAMPLE_W      = 32;
    localparam int SKIP_COUNT_W  = 15;
    localparam int INDEX_FIELD_WORDS       = 8192;
    localparam int DEF_MAX_FRAME_WORDS     = 8192;
    localparam int OUT_TDATA_W             = 64;

    // one incoming payload word with its frame markers
    typedef struct packed {
        logic [WORD_W-1:0] word;
        logic              first_word;
        logic              last_word;
    } t_word_in;

    // one peak descriptor
    typedef struct packed {
        logic                closed_by_end;
        logic [LENGTH_W-1:0] peak_length;
        logic [INDEX_W-1:0]  peak_word_pos;
        logic [SAMPLE_W-1:0] peak_sample_pos;
    } t_peak;

endpackage

// ----- rtl/zspd_step.sv -----
// per-word decode: frame state registers and the peak closing logic
// depends on zspd_pkg and zero_suppressed_peak_decoder_assert.svh
`include "zero_suppressed_peak_decoder_assert.svh"

module zspd_step #(
    parameter int MAX_FRAME_WORDS = zspd_pkg::DEF_MAX_FRAME_WORDS
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_step,
    input  zspd_pkg::t_word_in i_in,
    output logic              o_emit,
    output zspd_pkg::t_peak   o_peak
);
    import zspd_pkg::*;

    localparam int IndexLimitInt =
        ((MAX_FRAME_WORDS < INDEX_FIELD_WORDS) ? MAX_FRAME_WORDS : INDEX_FIELD_WORDS) - 1;
    localparam logic [INDEX_W-1:0] INDEX_LIMIT = INDEX_W'(IndexLimitInt);

    logic [INDEX_W-1:0]  r_word_index,  n_word_index;
    logic [SAMPLE_W-1:0] r_sample_cnt,  n_sample_cnt;
    logic                r_after_skip,  n_after_skip;
    logic                r_inside_peak, n_inside_peak;
    logic [INDEX_W-1:0]  r_start_word,  n_start_word;
    logic [SAMPLE_W-1:0] r_start_sample, n_start_sample;

    logic                is_skip;
    logic [INDEX_W-1:0]  cur_index;
    logic [SAMPLE_W-1:0] base_cnt;
    logic                base_after_skip;
    logic                base_inside;
    logic [SAMPLE_W-1:0] addend;
    logic [SAMPLE_W:0]   sum;
    logic [SAMPLE_W-1:0] sat_sum;
    logic [INDEX_W-1:0]  adv_index;

    assign is_skip = i_in.word[WORD_W-1];

    // frame start clears the running state before the word is handled
    always_comb begin
        if (i_in.first_word) begin
            cur_index       = '0;
            base_cnt        = '0;
            base_after_skip = 1'b1;
            base_inside     = 1'b0;
        end else begin
            cur_index       = r_word_index;
            base_cnt        = r_sample_cnt;
            base_after_skip = r_after_skip;
            base_inside     = r_inside_peak;
        end
    end

    // one saturating adder serves both skip counts and single samples
    assign addend  = is_skip ? SAMPLE_W'(i_in.word[SKIP_COUNT_W-1:0]) : SAMPLE_W'(1);
    assign sum     = {1'b0, base_cnt} + {1'b0, addend};
    assign sat_sum = sum[SAMPLE_W] ? '1 : sum[SAMPLE_W-1:0];

    assign adv_index = (cur_index < INDEX_LIMIT) ? cur_index + INDEX_W'(1) : cur_index;

    // next state and result
    always_comb begin
        n_word_index   = adv_index;
        n_sample_cnt   = sat_sum;
        n_after_skip   = base_after_skip;
        n_inside_peak  = base_inside;
        n_start_word   = r_start_word;
        n_start_sample = r_start_sample;
        o_emit         = 1'b0;
        o_peak.peak_sample_pos = r_start_sample;
        o_peak.peak_word_pos   = r_start_word;
        o_peak.peak_length     = LENGTH_W'({1'b0, cur_index} - {1'b0, r_start_word});
        o_peak.closed_by_end   = 1'b0;

        if (i_in.first_word && is_skip) begin
            // leading skip counts a single position
            n_sample_cnt  = SAMPLE_W'(1);
            n_after_skip  = 1'b1;
            n_inside_peak = 1'b0;
        end else begin
            if (is_skip) begin
                o_emit        = !base_after_skip && base_inside;
                n_inside_peak = 1'b0;
                n_after_skip  = 1'b1;
            end else begin
                if (base_after_skip) begin
                    n_start_sample = base_cnt;
                    n_start_word   = cur_index;
                    n_inside_peak  = 1'b1;
                end
                n_after_skip = 1'b0;
            end
            // frame end closes a peak still open
            if (i_in.last_word) begin
                if (n_inside_peak && !o_emit) begin
                    o_emit                 = 1'b1;
                    o_peak.peak_sample_pos = n_start_sample;
                    o_peak.peak_word_pos   = n_start_word;
                    o_peak.peak_length     = LENGTH_W'({1'b0, cur_index}
                                             + LENGTH_W'(1) - {1'b0, n_start_word});
                    o_peak.closed_by_end   = 1'b1;
                end
                n_inside_peak = 1'b0;
                n_after_skip  = 1'b1;
            end
        end
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_word_index   <= '0;
            r_sample_cnt   <= '0;
            r_after_skip   <= 1'b1;
            r_inside_peak  <= 1'b0;
            r_start_word   <= '0;
            r_start_sample <= '0;
        end else if (i_step) begin
            r_word_index   <= n_word_index;
            r_sample_cnt   <= n_sample_cnt;
            r_after_skip   <= n_after_skip;
            r_inside_peak  <= n_inside_peak;
            r_start_word   <= n_start_word;
            r_start_sample <= n_start_sample;
        end
    end

    // word index never passes the frame limit
    `ZSPD_ASSERT(a_index_limit, r_word_index <= INDEX_LIMIT)
    // a last word always leaves the frame closed
    `ZSPD_ASSERT(a_last_closes, (i_step && i_in.last_word) |=> (!r_inside_peak && r_after_skip))
    // reset restarts the frame state
    `ZSPD_ASSERT_ALWAYS(a_reset_state, !i_rst_n |=> (r_word_index == '0 && !r_inside_peak))

endmodule

// ----- rtl/zero_suppressed_peak_decoder.sv -----
// zero-suppressed peak decoder: input word register, decode step, result register
// a peak passes the input word register and the result register before the master side shows it
// throughput: one word per cycle while the master side takes each peak; the saturating add is combinational
// a peak held on the master side stalls the slave side once the input register
// is full; reset clears counters, flags and both valids
// depends on zspd_pkg, zspd_step and zero_suppressed_peak_decoder_assert.svh
`include "zero_suppressed_peak_decoder_assert.svh"

module zero_suppressed_peak_decoder #(
    parameter int MAX_FRAME_WORDS = zspd_pkg::DEF_MAX_FRAME_WORDS
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // slave side
    input  logic                                i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    input  logic [zspd_pkg::WORD_W-1:0]         i_s_axis_tdata,  // word
    input  logic                                i_s_axis_tuser,  // first_word
    input  logic                                i_s_axis_tlast,  // last_word
    // master side
    output logic                                o_m_axis_tvalid,
    input  logic                                i_m_axis_tready,
    // peak_sample_pos, peak_word_pos, peak_length, zero pad
    output logic [zspd_pkg::OUT_TDATA_W-1:0]    o_m_axis_tdata,
    output logic                                o_m_axis_tuser   // closed_by_end
);
    import zspd_pkg::*;

    localparam int IndexLimitInt =
        ((MAX_FRAME_WORDS < INDEX_FIELD_WORDS) ? MAX_FRAME_WORDS : INDEX_FIELD_WORDS) - 1;
    localparam logic [INDEX_W-1:0] INDEX_LIMIT = INDEX_W'(IndexLimitInt);
    localparam int PadW = OUT_TDATA_W - SAMPLE_W - INDEX_W - LENGTH_W;

    logic     r_in_valid;
    t_word_in r_in;
    logic     r_out_valid;
    t_peak    r_out;
    logic     w_proceed;
    logic     w_emit;
    t_peak    w_peak;

    // a held word moves on when the result slot is free or being emptied
    assign w_proceed       = r_in_valid && (!r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_in_valid || w_proceed;

    // input word register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_in.word       <= i_s_axis_tdata;
            r_in.first_word <= i_s_axis_tuser;
            r_in.last_word  <= i_s_axis_tlast;
        end
    end

    zspd_step #(
        .MAX_FRAME_WORDS (MAX_FRAME_WORDS)
    ) u_step (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (w_proceed),
        .i_in    (r_in),
        .o_emit  (w_emit),
        .o_peak  (w_peak)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_proceed) begin
            r_out_valid <= w_emit;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_proceed && w_emit) begin
            r_out <= w_peak;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {PadW'(0), r_out.peak_length, r_out.peak_word_pos,
                              r_out.peak_sample_pos};
    assign o_m_axis_tuser  = r_out.closed_by_end;

    // an empty result slot never stalls the slave side
    `ZSPD_ASSERT(a_ready_when_empty, !o_m_axis_tvalid |-> o_s_axis_tready)
    // a shown peak starts inside the frame limit
    `ZSPD_ASSERT(a_word_pos_range, o_m_axis_tvalid |-> (r_out.peak_word_pos <= INDEX_LIMIT))
    // a held word that cannot move stays held
    `ZSPD_ASSERT(a_hold_word, (r_in_valid && !w_proceed) |=> r_in_valid)
    // reset empties the result slot
    `ZSPD_ASSERT_ALWAYS(a_reset_empty, !i_rst_n |=> !o_m_axis_tvalid)

endmodule
